@@ src/atlt_pkg.sv @@
`default_nettype none

package atlt_pkg;

  localparam int CmdMaxLenDefault     = 16;
  localparam int ParamMaxLenDefault   = 32;
  localparam int ParamMaxCountDefault = 8;

  localparam int CmdLenW   = 5;
  localparam int ParamLenW = 6;
  localparam int ParamNumW = 4;

  typedef enum logic [1:0] {
    KIND_CMD     = 2'd0,
    KIND_PARAM   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FMT_ATTEST   = 2'd0,
    FMT_RESPONSE = 2'd1,
    FMT_NOTICE   = 2'd2,
    FMT_USER     = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_CMD_TOO_LONG  = 2'd1,
    ST_PARAM_TOO_LONG = 2'd2,
    ST_TOO_MANY      = 2'd3
  } status_t;

  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChGt    = 8'h3e;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChO     = 8'h4f;
  localparam logic [7:0] ChK     = 8'h4b;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef struct packed {
    logic [7:0] char_value;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [1:0] record_kind;
    logic [3:0] token_index;
    logic [5:0] char_position;
    logic [7:0] out_char;
    logic [1:0] format;
    logic [1:0] status;
    logic [3:0] param_count;
  } out_item_t;

endpackage

`default_nettype wire

@@ src/atlt_in_reg.sv @@
`default_nettype none

module atlt_in_reg (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire atlt_pkg::in_item_t in_data,
  input  wire               advance,
  output logic              item_valid,
  output atlt_pkg::in_item_t item
);

  logic               valid_r;
  logic               valid_nxt;
  atlt_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

`default_nettype wire

@@ src/atlt_parser.sv @@
`default_nettype none

module atlt_parser #(
  parameter int CMD_MAX_LEN     = atlt_pkg::CmdMaxLenDefault,
  parameter int PARAM_MAX_LEN   = atlt_pkg::ParamMaxLenDefault,
  parameter int PARAM_MAX_COUNT = atlt_pkg::ParamMaxCountDefault
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 advance,
  input  wire atlt_pkg::in_item_t item,
  output logic                res_valid,
  output atlt_pkg::out_item_t res
);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_CMD   = 2'd1,
    PH_PARAM = 2'd2,
    PH_ERR   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OKM_EMPTY = 2'd0,
    OKM_O     = 2'd1,
    OKM_OK    = 2'd2,
    OKM_NONE  = 2'd3
  } okm_t;

  localparam logic [atlt_pkg::CmdLenW-1:0]   CmdMax   = atlt_pkg::CmdLenW'(CMD_MAX_LEN);
  localparam logic [atlt_pkg::ParamLenW-1:0] ParMax   = atlt_pkg::ParamLenW'(PARAM_MAX_LEN);
  localparam logic [atlt_pkg::ParamNumW-1:0] CountMax = atlt_pkg::ParamNumW'(PARAM_MAX_COUNT);

  phase_t                            phase_r, phase_nxt;
  atlt_pkg::fmt_t                    fmt_r, fmt_nxt;
  logic [atlt_pkg::CmdLenW-1:0]      cmd_len_r, cmd_len_nxt;
  logic [atlt_pkg::ParamLenW-1:0]    par_len_r, par_len_nxt;
  logic [atlt_pkg::ParamNumW-1:0]    par_num_r, par_num_nxt;
  okm_t                              okm_r, okm_nxt;
  atlt_pkg::status_t                 err_r, err_nxt;

  always_comb begin
    logic [7:0]     ch;
    logic [7:0]     cmd_delim;
    logic [7:0]     par_delim;
    logic           skip;
    atlt_pkg::fmt_t sum_fmt;
    atlt_pkg::status_t sum_st;
    logic [atlt_pkg::ParamNumW-1:0] sum_cnt;

    ch          = item.char_value;
    skip        = 1'b0;
    cmd_delim   = atlt_pkg::ChColon;
    par_delim   = atlt_pkg::ChComma;
    sum_fmt     = fmt_r;
    sum_st      = atlt_pkg::ST_OK;
    sum_cnt     = '0;
    phase_nxt   = phase_r;
    fmt_nxt     = fmt_r;
    cmd_len_nxt = cmd_len_r;
    par_len_nxt = par_len_r;
    par_num_nxt = par_num_r;
    okm_nxt     = okm_r;
    err_nxt     = err_r;
    res_valid   = 1'b0;
    res         = '0;

    if (advance) begin
      if (item.end_of_message) begin
        if (phase_r == PH_PARAM && par_len_r != '0) begin
          if (par_num_r >= CountMax) begin
            phase_nxt = PH_ERR;
            err_nxt   = atlt_pkg::ST_TOO_MANY;
          end else begin
            par_num_nxt = par_num_r + 1'b1;
          end
        end
        if (okm_r == OKM_EMPTY || okm_r == OKM_OK) begin
          sum_fmt = atlt_pkg::FMT_ATTEST;
        end else if (phase_nxt == PH_ERR) begin
          sum_st = err_nxt;
        end else if (phase_nxt == PH_PARAM) begin
          sum_cnt = par_num_nxt;
        end
        res_valid         = 1'b1;
        res.record_kind   = atlt_pkg::KIND_SUMMARY;
        res.format        = sum_fmt;
        res.status        = sum_st;
        res.param_count   = sum_cnt;
        phase_nxt   = PH_START;
        fmt_nxt     = atlt_pkg::FMT_ATTEST;
        cmd_len_nxt = '0;
        par_len_nxt = '0;
        par_num_nxt = '0;
        okm_nxt     = OKM_EMPTY;
        err_nxt     = atlt_pkg::ST_OK;
      end else if (ch != atlt_pkg::ChNul) begin
        case (okm_r)
          OKM_EMPTY: okm_nxt = (ch == atlt_pkg::ChO) ? OKM_O : OKM_NONE;
          OKM_O:     okm_nxt = (ch == atlt_pkg::ChK) ? OKM_OK : OKM_NONE;
          default:   okm_nxt = OKM_NONE;
        endcase

        if (phase_r == PH_START) begin
          phase_nxt = PH_CMD;
          if (ch == atlt_pkg::ChPlus) begin
            fmt_nxt = atlt_pkg::FMT_RESPONSE;
            skip    = 1'b1;
          end else if (ch == atlt_pkg::ChGt) begin
            fmt_nxt = atlt_pkg::FMT_NOTICE;
            skip    = 1'b1;
          end else begin
            fmt_nxt = atlt_pkg::FMT_USER;
          end
        end

        if (fmt_nxt == atlt_pkg::FMT_USER) begin
          cmd_delim = atlt_pkg::ChSpace;
          par_delim = atlt_pkg::ChSpace;
        end

        if (!skip) begin
          case (phase_nxt)
            PH_CMD: begin
              if (ch == cmd_delim) begin
                phase_nxt = PH_PARAM;
              end else if (cmd_len_r >= CmdMax) begin
                phase_nxt = PH_ERR;
                err_nxt   = atlt_pkg::ST_CMD_TOO_LONG;
              end else begin
                res_valid         = 1'b1;
                res.record_kind   = atlt_pkg::KIND_CMD;
                res.char_position = {1'b0, cmd_len_r};
                res.out_char      = ch;
                res.format        = fmt_nxt;
                cmd_len_nxt       = cmd_len_r + 1'b1;
              end
            end
            PH_PARAM: begin
              if (ch == par_delim) begin
                if (par_len_r != '0) begin
                  if (par_num_r >= CountMax) begin
                    phase_nxt = PH_ERR;
                    err_nxt   = atlt_pkg::ST_TOO_MANY;
                  end else begin
                    par_num_nxt = par_num_r + 1'b1;
                    par_len_nxt = '0;
                  end
                end
              end else if (par_len_r >= ParMax) begin
                phase_nxt = PH_ERR;
                err_nxt   = atlt_pkg::ST_PARAM_TOO_LONG;
              end else begin
                res_valid         = 1'b1;
                res.record_kind   = atlt_pkg::KIND_PARAM;
                res.token_index   = par_num_r;
                res.char_position = par_len_r;
                res.out_char      = ch;
                res.format        = fmt_nxt;
                par_len_nxt       = par_len_r + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      fmt_r     <= atlt_pkg::FMT_ATTEST;
      cmd_len_r <= '0;
      par_len_r <= '0;
      par_num_r <= '0;
      okm_r     <= OKM_EMPTY;
      err_r     <= atlt_pkg::ST_OK;
    end else begin
      phase_r   <= phase_nxt;
      fmt_r     <= fmt_nxt;
      cmd_len_r <= cmd_len_nxt;
      par_len_r <= par_len_nxt;
      par_num_r <= par_num_nxt;
      okm_r     <= okm_nxt;
      err_r     <= err_nxt;
    end
  end

  a_eom_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item.end_of_message) |=> (phase_r == PH_START && okm_r == OKM_EMPTY))
    else $error("state not cleared after message end");

  a_cmd_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_len_r <= CmdMax)
    else $error("command length beyond limit");

  a_par_len: assert property (@(posedge clk) disable iff (!rst_n)
    par_len_r <= ParMax)
    else $error("parameter length beyond limit");

  a_par_num: assert property (@(posedge clk) disable iff (!rst_n)
    par_num_r <= CountMax)
    else $error("parameter count beyond limit");

  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != atlt_pkg::ST_OK) |-> (phase_r == PH_ERR))
    else $error("error code set outside error phase");

endmodule

`default_nettype wire

@@ src/atlt_out_reg.sv @@
`default_nettype none

module atlt_out_reg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 advance,
  input  wire                 res_valid,
  input  wire atlt_pkg::out_item_t res,
  output logic                out_valid,
  input  wire                 out_ready,
  output atlt_pkg::out_item_t out_data
);

  logic                valid_r;
  logic                valid_nxt;
  atlt_pkg::out_item_t data_r;

  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance && res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      data_r <= res;
    end
  end

endmodule

`default_nettype wire

@@ src/at_line_tokenizer_core.sv @@
// at_line_tokenizer_core: streaming tokenizer for one AT command line
// input channel (in_valid / in_ready / in_data): one message byte per
//   transaction, or a terminator with end_of_message set; zero bytes are dropped
// result channel (out_valid / out_ready / out_data): command bytes, parameter
//   bytes with their token index, and one summary record per terminator
// byte records are provisional; the summary gives format, status and count
// path: an item passes the input register, then the parser logic, and its
//   record, if any, is registered in the output register
// throughput: one input transaction per cycle while no output record is held;
//   the parser state updates once per item between the two registers
// items that produce no record still pass through the parser
// receiver stall: a held output record stops the parser; in_ready falls once
//   the input register is also full, and no transaction is dropped
// reset (rst_n low, synchronous): both registers empty, parser back at the
//   start of a message
`default_nettype none

module at_line_tokenizer_core #(
  parameter int CMD_MAX_LEN     = atlt_pkg::CmdMaxLenDefault,
  parameter int PARAM_MAX_LEN   = atlt_pkg::ParamMaxLenDefault,
  parameter int PARAM_MAX_COUNT = atlt_pkg::ParamMaxCountDefault
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire atlt_pkg::in_item_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output atlt_pkg::out_item_t out_data
);

  logic                item_valid;
  atlt_pkg::in_item_t  item;
  logic                advance;
  logic                res_valid;
  atlt_pkg::out_item_t res;

  assign advance = item_valid && (!out_valid || out_ready);

  atlt_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  atlt_parser #(
    .CMD_MAX_LEN     (CMD_MAX_LEN),
    .PARAM_MAX_LEN   (PARAM_MAX_LEN),
    .PARAM_MAX_COUNT (PARAM_MAX_COUNT)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  atlt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int StallLimit = 2000;
  localparam int ItemTarget = 1400;

  typedef enum logic [1:0] {
    SEEK_LEAD  = 2'd0,
    IN_COMMAND = 2'd1,
    IN_PARAMS  = 2'd2,
    IN_ERROR   = 2'd3
  } line_phase_t;

  typedef enum logic [1:0] {
    OKM_EMPTY = 2'd0,
    OKM_O     = 2'd1,
    OKM_OK    = 2'd2,
    OKM_NONE  = 2'd3
  } ok_track_t;

  class line_record_scoreboard;
    atlt_pkg::out_item_t pending_records[$];
    int unsigned         fail_count;
    line_phase_t         phase;
    atlt_pkg::fmt_t      fmt_found;
    int unsigned         cmd_len;
    int unsigned         par_len;
    int unsigned         par_num;
    ok_track_t           ok_seen;
    atlt_pkg::status_t   err_status;

    function new();
      fail_count = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase      = SEEK_LEAD;
      fmt_found  = atlt_pkg::FMT_ATTEST;
      cmd_len    = 0;
      par_len    = 0;
      par_num    = 0;
      ok_seen    = OKM_EMPTY;
      err_status = atlt_pkg::ST_OK;
    endfunction

    function void raise_error(atlt_pkg::status_t code);
      phase      = IN_ERROR;
      err_status = code;
    endfunction

    function void take_input(atlt_pkg::in_item_t it);
      atlt_pkg::out_item_t rec;
      logic [7:0]          ch;
      logic [7:0]          cmd_delim;
      logic [7:0]          par_delim;
      ch  = it.char_value;
      rec = '0;
      if (it.end_of_message) begin
        if (phase == IN_PARAMS && par_len > 0) begin
          if (par_num >= atlt_pkg::ParamMaxCountDefault) raise_error(atlt_pkg::ST_TOO_MANY);
          else par_num++;
        end
        rec.record_kind = atlt_pkg::KIND_SUMMARY;
        rec.format      = fmt_found;
        if (ok_seen == OKM_EMPTY || ok_seen == OKM_OK) begin
          rec.format = atlt_pkg::FMT_ATTEST;
        end else if (phase == IN_ERROR) begin
          rec.status = err_status;
        end else if (phase == IN_PARAMS) begin
          rec.param_count = 4'(par_num);
        end
        pending_records.push_back(rec);
        clear_line();
        return;
      end
      if (ch == atlt_pkg::ChNul) return;

      case (ok_seen)
        OKM_EMPTY: begin
          if (ch == atlt_pkg::ChO) ok_seen = OKM_O;
          else ok_seen = OKM_NONE;
        end
        OKM_O: begin
          if (ch == atlt_pkg::ChK) ok_seen = OKM_OK;
          else ok_seen = OKM_NONE;
        end
        default: ok_seen = OKM_NONE;
      endcase

      if (phase == SEEK_LEAD) begin
        phase = IN_COMMAND;
        if (ch == atlt_pkg::ChPlus) begin
          fmt_found = atlt_pkg::FMT_RESPONSE;
          return;
        end
        if (ch == atlt_pkg::ChGt) begin
          fmt_found = atlt_pkg::FMT_NOTICE;
          return;
        end
        fmt_found = atlt_pkg::FMT_USER;
      end

      if (fmt_found == atlt_pkg::FMT_USER) begin
        cmd_delim = atlt_pkg::ChSpace;
        par_delim = atlt_pkg::ChSpace;
      end else begin
        cmd_delim = atlt_pkg::ChColon;
        par_delim = atlt_pkg::ChComma;
      end

      if (phase == IN_COMMAND) begin
        if (ch == cmd_delim) begin
          phase = IN_PARAMS;
        end else if (cmd_len >= atlt_pkg::CmdMaxLenDefault) begin
          raise_error(atlt_pkg::ST_CMD_TOO_LONG);
        end else begin
          rec.record_kind   = atlt_pkg::KIND_CMD;
          rec.char_position = 6'(cmd_len);
          rec.out_char      = ch;
          rec.format        = fmt_found;
          pending_records.push_back(rec);
          cmd_len++;
        end
      end else if (phase == IN_PARAMS) begin
        if (ch == par_delim) begin
          if (par_len > 0) begin
            if (par_num >= atlt_pkg::ParamMaxCountDefault) begin
              raise_error(atlt_pkg::ST_TOO_MANY);
            end else begin
              par_num++;
              par_len = 0;
            end
          end
        end else if (par_len >= atlt_pkg::ParamMaxLenDefault) begin
          raise_error(atlt_pkg::ST_PARAM_TOO_LONG);
        end else begin
          rec.record_kind   = atlt_pkg::KIND_PARAM;
          rec.token_index   = 4'(par_num);
          rec.char_position = 6'(par_len);
          rec.out_char      = ch;
          rec.format        = fmt_found;
          pending_records.push_back(rec);
          par_len++;
        end
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_record(atlt_pkg::out_item_t got);
      atlt_pkg::out_item_t want;
      if (pending_records.size() == 0) begin
        $error("unexpected record: kind %0d char %0d", got.record_kind, got.out_char);
        fail_count++;
        return;
      end
      want = pending_records.pop_front();
      compare_field("record_kind", 8'(want.record_kind), 8'(got.record_kind));
      compare_field("token_index", 8'(want.token_index), 8'(got.token_index));
      compare_field("char_position", 8'(want.char_position), 8'(got.char_position));
      compare_field("out_char", want.out_char, got.out_char);
      compare_field("format", 8'(want.format), 8'(got.format));
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("param_count", 8'(want.param_count), 8'(got.param_count));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  atlt_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  atlt_pkg::out_item_t out_data;

  line_record_scoreboard sb;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  logic        send_idle_on = 1'b1;
  logic        recv_idle_on = 1'b1;

  at_line_tokenizer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_record(out_data);
      if (in_valid && in_ready) sb.take_input(in_data);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("at_line_tokenizer_core regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_idle_on = !recv_idle_on;
      gap = recv_idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [7:0] rand_char(logic [7:0] avoid);
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) != 0) c = 8'($urandom_range(8'h21, 8'h7e));
      else c = 8'($urandom_range(1, 255));
    end while (c == avoid);
    return c;
  endfunction

  task automatic send_item(logic [7:0] ch, logic eom);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_idle_on = !send_idle_on;
    gap = send_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_value: ch, end_of_message: eom};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] ch);
    send_item(ch, 1'b0);
  endtask

  task automatic send_term();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_token(int unsigned len, logic [7:0] avoid);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 29) == 0) send_byte(atlt_pkg::ChNul);
      send_byte(rand_char(avoid));
    end
  endtask

  task automatic random_message();
    int unsigned pick;
    int unsigned n_cmd;
    int unsigned n_par;
    int unsigned plen;
    int unsigned k;
    logic [7:0]  lead;
    logic [7:0]  cmd_delim;
    logic [7:0]  par_delim;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // raw noise, zero bytes included
      n_cmd = $urandom_range(0, 40);
      for (k = 0; k < n_cmd; k++) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 12) begin
      pick = $urandom_range(0, 3);
      if (pick >= 1) send_byte(atlt_pkg::ChO);
      if (pick >= 2) send_byte(atlt_pkg::ChK);
      if (pick == 3) send_token($urandom_range(1, 3), atlt_pkg::ChNul);
    end else begin
      case ($urandom_range(0, 2))
        0: lead = atlt_pkg::ChPlus;
        1: lead = atlt_pkg::ChGt;
        default: begin
          do lead = rand_char(atlt_pkg::ChPlus); while (lead == atlt_pkg::ChGt);
        end
      endcase
      if (lead == atlt_pkg::ChPlus || lead == atlt_pkg::ChGt) begin
        cmd_delim = atlt_pkg::ChColon;
        par_delim = atlt_pkg::ChComma;
      end else begin
        cmd_delim = atlt_pkg::ChSpace;
        par_delim = atlt_pkg::ChSpace;
      end
      send_byte(lead);
      if ($urandom_range(0, 9) == 0)
        n_cmd = $urandom_range(atlt_pkg::CmdMaxLenDefault - 2,
                               atlt_pkg::CmdMaxLenDefault + 2);
      else
        n_cmd = $urandom_range(0, 8);
      send_token(n_cmd, cmd_delim);
      if ($urandom_range(0, 9) != 0) begin
        send_byte(cmd_delim);
        if ($urandom_range(0, 9) == 0)
          n_par = $urandom_range(atlt_pkg::ParamMaxCountDefault - 1,
                                 atlt_pkg::ParamMaxCountDefault + 2);
        else
          n_par = $urandom_range(0, 4);
        for (k = 0; k < n_par; k++) begin
          if ($urandom_range(0, 11) == 0)
            plen = $urandom_range(atlt_pkg::ParamMaxLenDefault - 2,
                                  atlt_pkg::ParamMaxLenDefault + 2);
          else
            plen = $urandom_range(0, 6);
          send_token(plen, par_delim);
          if (k + 1 < n_par || $urandom_range(0, 4) == 0) send_byte(par_delim);
        end
      end
    end
    send_term();
  endtask

  initial begin
    sb = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty line, bare OK
    send_term();
    send_byte(atlt_pkg::ChO);
    send_byte(atlt_pkg::ChK);
    send_term();
    // response with an empty token
    send_byte(atlt_pkg::ChPlus);
    send_byte("A");
    send_byte(atlt_pkg::ChColon);
    send_byte("1");
    send_byte(atlt_pkg::ChComma);
    send_byte(atlt_pkg::ChComma);
    send_byte("2");
    send_term();
    // notice with delimiter only
    send_byte(atlt_pkg::ChGt);
    send_byte("B");
    send_byte(atlt_pkg::ChColon);
    send_term();
    // user control with a zero byte
    send_byte("x");
    send_byte(atlt_pkg::ChNul);
    send_byte(atlt_pkg::ChSpace);
    send_byte("y");
    send_term();
    send_byte(8'hff);
    send_term();

    while (items_sent < ItemTarget) random_message();
    in_valid <= 1'b0;

    while (sb.pending_records.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("at_line_tokenizer_core regression: pass");
    end else begin
      $display("at_line_tokenizer_core regression: fail");
    end
    $finish;
  end

endmodule
